### rtl/adm_pkg.sv
// ----------------------------------------------------------------------------
// adm_pkg: shared definitions for the admittance matrix stamper
// Operation and status codes, field widths, register map and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package adm_pkg;

  // Default sizing for the top level parameters
  localparam int MAX_NODES_DEF   = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int OP_W     = 3;
  localparam int IDX_W    = 6;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SHUNT      = 3'd0;
  localparam logic [OP_W-1:0] OP_SERIES     = 3'd1;
  localparam logic [OP_W-1:0] OP_NODE_CUR   = 3'd2;
  localparam logic [OP_W-1:0] OP_BRANCH_CUR = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  // Configuration register map: register index sits above the byte offset
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_ADDR_W   = CFG_IDX_W + 2;
  localparam int CFG_DATA_W   = 32;
  localparam int NODE_COUNT_W = 7;

  localparam logic [CFG_IDX_W-1:0]    REG_NODE_COUNT   = 1'd0;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

endpackage

`default_nettype wire

### rtl/adm_ram.sv
// ----------------------------------------------------------------------------
// adm_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/adm_sat_acc.sv
// ----------------------------------------------------------------------------
// adm_sat_acc: saturating accumulate lane
// Adds or subtracts a signed addend to a signed value, clamping to range.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_sat_acc #(
  parameter int VALUE_WIDTH = adm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [VALUE_WIDTH-1:0] acc_in,
  input  wire logic [VALUE_WIDTH-1:0] addend,
  input  wire logic                   subtract,
  output logic      [VALUE_WIDTH-1:0] acc_out,
  output logic                        saturated
);

  logic [VALUE_WIDTH:0] wide_sum;

  always_comb begin
    if (subtract) begin
      wide_sum = {acc_in[VALUE_WIDTH-1], acc_in} - {addend[VALUE_WIDTH-1], addend};
    end else begin
      wide_sum = {acc_in[VALUE_WIDTH-1], acc_in} + {addend[VALUE_WIDTH-1], addend};
    end
  end

  // overflow when the extra sign bit disagrees with the result sign
  assign saturated = wide_sum[VALUE_WIDTH] ^ wide_sum[VALUE_WIDTH-1];
  assign acc_out   = saturated ?
                     {wide_sum[VALUE_WIDTH], {(VALUE_WIDTH-1){~wide_sum[VALUE_WIDTH]}}} :
                     wide_sum[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

### rtl/adm_cfg_regs.sv
// ----------------------------------------------------------------------------
// adm_cfg_regs: configuration register file
// APB-style slave holding the active node count.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [adm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [adm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [adm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [adm_pkg::NODE_COUNT_W-1:0]  node_count
);

  logic [adm_pkg::CFG_IDX_W-1:0]    reg_idx;
  logic                             wr_en;
  logic [adm_pkg::NODE_COUNT_W-1:0] node_count_r;
  logic [adm_pkg::NODE_COUNT_W-1:0] node_count_nxt;

  assign reg_idx = paddr[adm_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    node_count_nxt = node_count_r;
    if (wr_en && (reg_idx == adm_pkg::REG_NODE_COUNT)) begin
      node_count_nxt = pwdata[adm_pkg::NODE_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= adm_pkg::NODE_COUNT_RESET;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  assign prdata     = (reg_idx == adm_pkg::REG_NODE_COUNT) ?
                      adm_pkg::CFG_DATA_W'(node_count_r) : '0;
  assign node_count = node_count_r;

endmodule

`default_nettype wire

### rtl/admittance_matrix_stamper.sv
// ----------------------------------------------------------------------------
// admittance_matrix_stamper: nodal admittance matrix and current stamper
// Accumulates G + jB and injected currents per stamp, saturating Q16.16.
// ----------------------------------------------------------------------------
// One transaction at a time runs through a read-modify-write sequencer over
// two simple dual port RAMs: the matrix RAM holds {B, G} per row and column,
// the current RAM holds {Im, Ir} per node. Each stamp step reads one entry,
// accumulates both lanes and writes back in the next cycle, one step per
// cycle, with the previous write forwarded when both nodes are the same.
// From acceptance an item runs through its stamp steps and a done state, where
// its result moves into the output register: one step for shunt, node current
// and read, two for branch current, four matrix steps for series branch, and
// none for a flagged node or an unknown operation. The output register lets
// the next transaction start while a result waits. After reset a clearing
// pass zeroes every entry of both RAMs, during which in_ready stays low;
// configuration writes are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module admittance_matrix_stamper #(
  parameter int MAX_NODES   = adm_pkg::MAX_NODES_DEF,
  parameter int VALUE_WIDTH = adm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [adm_pkg::OP_W-1:0]     in_operation,
  input  wire logic        [adm_pkg::IDX_W-1:0]    in_node_i,
  input  wire logic        [adm_pkg::IDX_W-1:0]    in_node_j,
  input  wire logic signed [adm_pkg::FIELD_W-1:0]  in_real_part,
  input  wire logic signed [adm_pkg::FIELD_W-1:0]  in_imag_part,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [adm_pkg::STATUS_W-1:0] out_status,
  output logic signed      [adm_pkg::FIELD_W-1:0]  out_conductance_entry,
  output logic signed      [adm_pkg::FIELD_W-1:0]  out_susceptance_entry,
  output logic signed      [adm_pkg::FIELD_W-1:0]  out_current_real_entry,
  output logic signed      [adm_pkg::FIELD_W-1:0]  out_current_imag_entry,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [adm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic        [adm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic             [adm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                     pready
);

  localparam int VW        = VALUE_WIDTH;
  localparam int DW        = 2 * VALUE_WIDTH;
  localparam int FW        = adm_pkg::FIELD_W;
  localparam int NW        = $clog2(MAX_NODES);
  localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
  localparam int MAW       = $clog2(MAT_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic [1:0] last_step(input logic [adm_pkg::OP_W-1:0] op);
    case (op)
      adm_pkg::OP_SERIES:     last_step = 2'd3;
      adm_pkg::OP_BRANCH_CUR: last_step = 2'd1;
      default:                last_step = 2'd0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [adm_pkg::NODE_COUNT_W-1:0] node_count;

  adm_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [1:0]     state_r, state_nxt;
  logic [1:0]     step_r, step_nxt;
  logic [MAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic           out_valid_r;

  logic idle, stepping, clearing, out_free;
  assign idle     = (state_r == ST_IDLE);
  assign stepping = (state_r == ST_STEP);
  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_ready;

  // --------------------------------------------------------------------------
  // Input decode and range check
  // --------------------------------------------------------------------------
  logic accept, op_known, need_j, i_bad, j_bad, in_bad, go;
  logic in_mat_op, in_cur_op;

  assign in_ready = idle;
  assign accept   = in_valid && idle;
  assign op_known = (in_operation <= adm_pkg::OP_READ);
  assign need_j   = (in_operation == adm_pkg::OP_SERIES) ||
                    (in_operation == adm_pkg::OP_BRANCH_CUR) ||
                    (in_operation == adm_pkg::OP_READ);
  assign i_bad    = (32'(in_node_i) >= 32'(node_count)) ||
                    (32'(in_node_i) >= 32'(MAX_NODES));
  assign j_bad    = (32'(in_node_j) >= 32'(node_count)) ||
                    (32'(in_node_j) >= 32'(MAX_NODES));
  assign in_bad   = i_bad || (need_j && j_bad);
  assign go       = accept && op_known && !in_bad;

  assign in_mat_op = (in_operation == adm_pkg::OP_SHUNT) ||
                     (in_operation == adm_pkg::OP_SERIES) ||
                     (in_operation == adm_pkg::OP_READ);
  assign in_cur_op = (in_operation == adm_pkg::OP_NODE_CUR) ||
                     (in_operation == adm_pkg::OP_BRANCH_CUR) ||
                     (in_operation == adm_pkg::OP_READ);

  // Clamp operands to the stored value range on entry
  logic [VW-1:0] re_in, im_in;
  logic          re_clip, im_clip;

  if (VW >= FW) begin : g_in_wide
    assign re_in   = VW'($signed(in_real_part));
    assign im_in   = VW'($signed(in_imag_part));
    assign re_clip = 1'b0;
    assign im_clip = 1'b0;
  end else begin : g_in_clamp
    logic [FW-VW:0] re_hi, im_hi;
    assign re_hi   = in_real_part[FW-1:VW-1];
    assign im_hi   = in_imag_part[FW-1:VW-1];
    assign re_clip = !((&re_hi) || !(|re_hi));
    assign im_clip = !((&im_hi) || !(|im_hi));
    assign re_in   = re_clip ? {in_real_part[FW-1], {(VW-1){~in_real_part[FW-1]}}} :
                               in_real_part[VW-1:0];
    assign im_in   = im_clip ? {in_imag_part[FW-1], {(VW-1){~in_imag_part[FW-1]}}} :
                               in_imag_part[VW-1:0];
  end

  // --------------------------------------------------------------------------
  // Item registers
  // --------------------------------------------------------------------------
  logic [adm_pkg::OP_W-1:0]     op_r;
  logic [NW-1:0]                i_r, j_r;
  logic [VW-1:0]                re_r, im_r;
  logic                         sat_r;
  logic [DW-1:0]                last_wr_r;
  logic [adm_pkg::STATUS_W-1:0] res_status_r;
  logic [FW-1:0]                res_g_r, res_b_r, res_ir_r, res_im_r;

  logic [1:0] last_n;
  logic       more, r_mat_op, r_cur_op, fwd, subtract;
  assign last_n   = last_step(op_r);
  assign more     = (step_r != last_n);
  assign r_mat_op = (op_r == adm_pkg::OP_SHUNT) || (op_r == adm_pkg::OP_SERIES);
  assign r_cur_op = (op_r == adm_pkg::OP_NODE_CUR) || (op_r == adm_pkg::OP_BRANCH_CUR);
  // every later step hits the entry written just before when both nodes match
  assign fwd      = stepping && (step_r != 2'd0) && (i_r == j_r);
  assign subtract = ((op_r == adm_pkg::OP_SERIES) && step_r[1]) ||
                    ((op_r == adm_pkg::OP_BRANCH_CUR) && (step_r == 2'd1));

  // --------------------------------------------------------------------------
  // Address generation
  // --------------------------------------------------------------------------
  logic [NW-1:0]  i_src, j_src;
  logic [MAW-1:0] row_i, row_j, a_ii, a_jj, a_ij, a_ji;
  logic [1:0]     rd_step;
  logic           rd_is_read;
  logic [MAW-1:0] mat_raddr, mat_step_addr, mat_waddr;
  logic [NW-1:0]  cur_raddr, cur_waddr;

  assign i_src = idle ? NW'(in_node_i) : i_r;
  assign j_src = idle ? NW'(in_node_j) : j_r;
  assign row_i = MAW'(i_src) * MAW'(MAX_NODES);
  assign row_j = MAW'(j_src) * MAW'(MAX_NODES);
  assign a_ii  = row_i + MAW'(i_src);
  assign a_ij  = row_i + MAW'(j_src);
  assign a_jj  = row_j + MAW'(j_src);
  assign a_ji  = row_j + MAW'(i_src);

  // next read: the first step at acceptance, then one step ahead of the write
  assign rd_step    = idle ? 2'd0 : step_r + 2'd1;
  assign rd_is_read = idle && (in_operation == adm_pkg::OP_READ);

  always_comb begin
    case (rd_step)
      2'd0:    mat_raddr = rd_is_read ? a_ij : a_ii;
      2'd1:    mat_raddr = a_jj;
      2'd2:    mat_raddr = a_ij;
      default: mat_raddr = a_ji;
    endcase
  end

  always_comb begin
    case (step_r)
      2'd0:    mat_step_addr = a_ii;
      2'd1:    mat_step_addr = a_jj;
      2'd2:    mat_step_addr = a_ij;
      default: mat_step_addr = a_ji;
    endcase
  end

  assign cur_raddr = (rd_step == 2'd0) ? i_src : j_src;
  assign mat_waddr = clearing ? clr_cnt_r : mat_step_addr;
  assign cur_waddr = clearing ? clr_cnt_r[NW-1:0] : ((step_r == 2'd0) ? i_r : j_r);

  // --------------------------------------------------------------------------
  // Memories and accumulate lanes
  // --------------------------------------------------------------------------
  logic          mat_re, cur_re, mat_we, cur_we;
  logic [DW-1:0] mat_rdata, cur_rdata, operand, step_wdata, mat_wdata, cur_wdata;
  logic [VW-1:0] re_sum, im_sum;
  logic          re_sat, im_sat, step_sat;

  assign mat_re = (go && in_mat_op) ||
                  (stepping && more && (op_r == adm_pkg::OP_SERIES));
  assign cur_re = (go && in_cur_op) ||
                  (stepping && more && (op_r == adm_pkg::OP_BRANCH_CUR));
  assign mat_we = clearing || (stepping && r_mat_op);
  assign cur_we = (clearing && (32'(clr_cnt_r) < 32'(MAX_NODES))) ||
                  (stepping && r_cur_op);

  assign operand    = fwd ? last_wr_r : (r_mat_op ? mat_rdata : cur_rdata);
  assign step_wdata = {im_sum, re_sum};
  assign step_sat   = re_sat || im_sat;
  assign mat_wdata  = clearing ? '0 : step_wdata;
  assign cur_wdata  = clearing ? '0 : step_wdata;

  adm_ram #(.WIDTH(DW), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk     (clk),
    .wr_en   (mat_we),
    .wr_addr (mat_waddr),
    .wr_data (mat_wdata),
    .rd_en   (mat_re),
    .rd_addr (mat_raddr),
    .rd_data (mat_rdata)
  );

  adm_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk     (clk),
    .wr_en   (cur_we),
    .wr_addr (cur_waddr),
    .wr_data (cur_wdata),
    .rd_en   (cur_re),
    .rd_addr (cur_raddr),
    .rd_data (cur_rdata)
  );

  adm_sat_acc #(.VALUE_WIDTH(VW)) u_acc_re (
    .acc_in    (operand[VW-1:0]),
    .addend    (re_r),
    .subtract  (subtract),
    .acc_out   (re_sum),
    .saturated (re_sat)
  );

  adm_sat_acc #(.VALUE_WIDTH(VW)) u_acc_im (
    .acc_in    (operand[DW-1:VW]),
    .addend    (im_r),
    .subtract  (subtract),
    .acc_out   (im_sum),
    .saturated (im_sat)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + MAW'(1);
        if (clr_cnt_r == MAW'(MAT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = 2'd0;
        if (accept) begin
          state_nxt = go ? ST_STEP : ST_DONE;
        end
      end
      ST_STEP: begin
        if (more) begin
          step_nxt = step_r + 2'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= 2'd0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: item, result and output registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_operation;
      i_r          <= NW'(in_node_i);
      j_r          <= NW'(in_node_j);
      re_r         <= re_in;
      im_r         <= im_in;
      sat_r        <= re_clip || im_clip;
      res_status_r <= (op_known && in_bad) ? adm_pkg::STATUS_RANGE : adm_pkg::STATUS_OK;
      res_g_r      <= '0;
      res_b_r      <= '0;
      res_ir_r     <= '0;
      res_im_r     <= '0;
    end
    if (stepping) begin
      last_wr_r <= step_wdata;
      sat_r     <= sat_r || step_sat;
      if (!more) begin
        res_status_r <= ((op_r != adm_pkg::OP_READ) && (sat_r || step_sat)) ?
                        adm_pkg::STATUS_SAT : adm_pkg::STATUS_OK;
      end
      if (op_r == adm_pkg::OP_READ) begin
        res_g_r  <= FW'($signed(mat_rdata[VW-1:0]));
        res_b_r  <= FW'($signed(mat_rdata[DW-1:VW]));
        res_ir_r <= FW'($signed(cur_rdata[VW-1:0]));
        res_im_r <= FW'($signed(cur_rdata[DW-1:VW]));
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_status             <= res_status_r;
      out_conductance_entry  <= res_g_r;
      out_susceptance_entry  <= res_b_r;
      out_current_real_entry <= res_ir_r;
      out_current_imag_entry <= res_im_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd |-> $past(mat_we || cur_we))
    else $error("forwarded operand without a write in the previous cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stepping |-> (step_r <= last_step(op_r)))
    else $error("step counter ran past the last step of the operation");

  a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing |-> !(mat_we && cur_we))
    else $error("matrix and current stores written in the same stamp step");

  a_read_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (mat_re || cur_re) |=> stepping)
    else $error("read data returned outside a stamp step");

endmodule

`default_nettype wire

### tb/sv/admittance_stamp_check.sv
// ----------------------------------------------------------------------------
// admittance_stamp_check: result checker for the admittance matrix stamper
// Tracks the node count register from the configuration bus, keeps its own
// copy of the G/B matrices and current vectors, stamps every accepted input
// transaction into it and compares each accepted result field by field
// against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module admittance_stamp_check (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [adm_pkg::OP_W-1:0]           in_operation,
  input  wire logic [adm_pkg::IDX_W-1:0]          in_node_i,
  input  wire logic [adm_pkg::IDX_W-1:0]          in_node_j,
  input  wire logic [adm_pkg::FIELD_W-1:0]        in_real_part,
  input  wire logic [adm_pkg::FIELD_W-1:0]        in_imag_part,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [adm_pkg::STATUS_W-1:0]       out_status,
  input  wire logic [adm_pkg::FIELD_W-1:0]        out_conductance_entry,
  input  wire logic [adm_pkg::FIELD_W-1:0]        out_susceptance_entry,
  input  wire logic [adm_pkg::FIELD_W-1:0]        out_current_real_entry,
  input  wire logic [adm_pkg::FIELD_W-1:0]        out_current_imag_entry,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [adm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [adm_pkg::CFG_DATA_W-1:0]     pwdata,
  input  wire logic                               pready,
  output int                                      mismatch_count,
  output int                                      pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW    = adm_pkg::FIELD_W;
  localparam int NODES = adm_pkg::MAX_NODES_DEF;
  localparam logic signed [FW-1:0] VAL_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] VAL_MIN = {1'b1, {(FW-1){1'b0}}};

  typedef struct packed {
    logic [adm_pkg::STATUS_W-1:0] status;
    logic [FW-1:0]                conductance;
    logic [FW-1:0]                susceptance;
    logic [FW-1:0]                current_real;
    logic [FW-1:0]                current_imag;
  } stamp_result_t;

  logic signed [FW-1:0]               g_mat  [NODES*NODES];
  logic signed [FW-1:0]               b_mat  [NODES*NODES];
  logic signed [FW-1:0]               ir_vec [NODES];
  logic signed [FW-1:0]               im_vec [NODES];
  logic [adm_pkg::NODE_COUNT_W-1:0]   node_count;
  bit                                 saturated;
  stamp_result_t                      expected_results[$];
  int                                 errors = 0;

  // Signed add or subtract clamped to the value range; flags any clamp.
  function automatic logic signed [FW-1:0] sat_acc(
    input logic signed [FW-1:0] acc_val,
    input logic signed [FW-1:0] operand,
    input bit                   subtract
  );
    logic [FW:0] wide;
    if (subtract) wide = {acc_val[FW-1], acc_val} - {operand[FW-1], operand};
    else          wide = {acc_val[FW-1], acc_val} + {operand[FW-1], operand};
    if (wide[FW] != wide[FW-1]) begin
      saturated = 1'b1;
      return wide[FW] ? VAL_MIN : VAL_MAX;
    end
    return wide[FW-1:0];
  endfunction

  function automatic stamp_result_t stamp_item(
    input logic [adm_pkg::OP_W-1:0]  op,
    input logic [adm_pkg::IDX_W-1:0] ni,
    input logic [adm_pkg::IDX_W-1:0] nj,
    input logic signed [FW-1:0]      re,
    input logic signed [FW-1:0]      im
  );
    stamp_result_t res;
    int            limit, i, j, ii, jj, ij, ji;
    bit            bad;
    res       = '0;
    saturated = 1'b0;
    i         = int'(ni);
    j         = int'(nj);
    ii        = i * NODES + i;
    jj        = j * NODES + j;
    ij        = i * NODES + j;
    ji        = j * NODES + i;
    limit     = (int'(node_count) < NODES) ? int'(node_count) : NODES;
    bad = (i >= limit) ||
          ((op == adm_pkg::OP_SERIES || op == adm_pkg::OP_BRANCH_CUR ||
            op == adm_pkg::OP_READ) && j >= limit);
    if (op > adm_pkg::OP_READ) return res;
    if (bad) begin
      res.status = adm_pkg::STATUS_RANGE;
      return res;
    end
    case (op)
      adm_pkg::OP_SHUNT: begin
        g_mat[ii] = sat_acc(g_mat[ii], re, 1'b0);
        b_mat[ii] = sat_acc(b_mat[ii], im, 1'b0);
      end
      adm_pkg::OP_SERIES: begin
        // each step sees the previous one when both nodes coincide
        g_mat[ii] = sat_acc(g_mat[ii], re, 1'b0);
        g_mat[jj] = sat_acc(g_mat[jj], re, 1'b0);
        g_mat[ij] = sat_acc(g_mat[ij], re, 1'b1);
        g_mat[ji] = sat_acc(g_mat[ji], re, 1'b1);
        b_mat[ii] = sat_acc(b_mat[ii], im, 1'b0);
        b_mat[jj] = sat_acc(b_mat[jj], im, 1'b0);
        b_mat[ij] = sat_acc(b_mat[ij], im, 1'b1);
        b_mat[ji] = sat_acc(b_mat[ji], im, 1'b1);
      end
      adm_pkg::OP_NODE_CUR: begin
        ir_vec[i] = sat_acc(ir_vec[i], re, 1'b0);
        im_vec[i] = sat_acc(im_vec[i], im, 1'b0);
      end
      adm_pkg::OP_BRANCH_CUR: begin
        ir_vec[i] = sat_acc(ir_vec[i], re, 1'b0);
        im_vec[i] = sat_acc(im_vec[i], im, 1'b0);
        ir_vec[j] = sat_acc(ir_vec[j], re, 1'b1);
        im_vec[j] = sat_acc(im_vec[j], im, 1'b1);
      end
      default: begin
        res.conductance  = g_mat[ij];
        res.susceptance  = b_mat[ij];
        res.current_real = ir_vec[i];
        res.current_imag = im_vec[i];
      end
    endcase
    if (saturated) res.status = adm_pkg::STATUS_SAT;
    return res;
  endfunction

  function automatic void check_field(
    input string         what,
    input logic [FW-1:0] want,
    input logic [FW-1:0] got
  );
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    stamp_result_t got, want;
    if (!rst_n) begin
      for (int k = 0; k < NODES * NODES; k++) begin
        g_mat[k] = '0;
        b_mat[k] = '0;
      end
      for (int k = 0; k < NODES; k++) begin
        ir_vec[k] = '0;
        im_vec[k] = '0;
      end
      node_count = adm_pkg::NODE_COUNT_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[adm_pkg::CFG_ADDR_W-1:2] == adm_pkg::REG_NODE_COUNT)
        node_count = pwdata[adm_pkg::NODE_COUNT_W-1:0];
      if (in_valid && in_ready)
        expected_results.push_back(stamp_item(in_operation, in_node_i, in_node_j,
                                              in_real_part, in_imag_part));
      if (out_valid && out_ready) begin
        got = {out_status, out_conductance_entry, out_susceptance_entry,
               out_current_real_entry, out_current_imag_entry};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, got.status);
        end else begin
          want = expected_results.pop_front();
          check_field("status", FW'(want.status), FW'(got.status));
          check_field("conductance_entry", want.conductance, got.conductance);
          check_field("susceptance_entry", want.susceptance, got.susceptance);
          check_field("current_real_entry", want.current_real, got.current_real);
          check_field("current_imag_entry", want.current_imag, got.current_imag);
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

`default_nettype wire

### tb/sv/admittance_matrix_stamper_tb.sv
// ----------------------------------------------------------------------------
// admittance_matrix_stamper_tb: top level bench for the stamper
// Drives directed and random stamp/read transactions under random idling on
// both channels, rewrites the node count between phases while the block is
// idle, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module admittance_matrix_stamper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W            = adm_pkg::OP_W;
  localparam int IDX_W           = adm_pkg::IDX_W;
  localparam int FIELD_W         = adm_pkg::FIELD_W;
  localparam int NODE_COUNT_W    = adm_pkg::NODE_COUNT_W;
  localparam int MAX_NODES       = adm_pkg::MAX_NODES_DEF;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 200;
  localparam int RANDOM_PHASES   = 6;
  localparam logic [FIELD_W-1:0] VAL_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] VAL_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [OP_W-1:0] OP_BAD_A = OP_W'(int'(adm_pkg::OP_READ) + 1);
  localparam logic [OP_W-1:0] OP_BAD_B = OP_W'(int'(adm_pkg::OP_READ) + 2);

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [OP_W-1:0]                    in_operation;
  logic [IDX_W-1:0]                   in_node_i;
  logic [IDX_W-1:0]                   in_node_j;
  logic [FIELD_W-1:0]                 in_real_part;
  logic [FIELD_W-1:0]                 in_imag_part;
  logic                               out_valid;
  logic                               out_ready;
  logic [adm_pkg::STATUS_W-1:0]       out_status;
  logic [FIELD_W-1:0]                 out_conductance_entry;
  logic [FIELD_W-1:0]                 out_susceptance_entry;
  logic [FIELD_W-1:0]                 out_current_real_entry;
  logic [FIELD_W-1:0]                 out_current_imag_entry;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [adm_pkg::CFG_ADDR_W-1:0]     paddr;
  logic [adm_pkg::CFG_DATA_W-1:0]     pwdata;
  logic [adm_pkg::CFG_DATA_W-1:0]     prdata;
  logic                               pready;
  int                                 mismatch_count;
  int                                 pending_count;

  bit steady        = 1'b0;
  bit hold_off_req  = 1'b0;
  int node_limit    = MAX_NODES;

  admittance_matrix_stamper u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_node_i              (in_node_i),
    .in_node_j              (in_node_j),
    .in_real_part           (in_real_part),
    .in_imag_part           (in_imag_part),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_conductance_entry  (out_conductance_entry),
    .out_susceptance_entry  (out_susceptance_entry),
    .out_current_real_entry (out_current_real_entry),
    .out_current_imag_entry (out_current_imag_entry),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  admittance_stamp_check u_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_node_i              (in_node_i),
    .in_node_j              (in_node_j),
    .in_real_part           (in_real_part),
    .in_imag_part           (in_imag_part),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_conductance_entry  (out_conductance_entry),
    .out_susceptance_entry  (out_susceptance_entry),
    .out_current_real_entry (out_current_real_entry),
    .out_current_imag_entry (out_current_imag_entry),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .pready                 (pready),
    .mismatch_count         (mismatch_count),
    .pending_count          (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [FIELD_W-1:0] random_value();
    int                 r;
    logic [FIELD_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // small magnitudes keep most sums clear of the rails
      v = $urandom_range(0, 'h3FFFF);
      if ($urandom_range(0, 1)) v = -v;
      return v;
    end
    if (r < 85) return $urandom;
    case ($urandom_range(0, 4))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return FIELD_W'(1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_node();
    if (node_limit > 0 && $urandom_range(0, 9) != 0)
      return IDX_W'($urandom_range(0, node_limit - 1));
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  task automatic cfg_write(input logic [NODE_COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {adm_pkg::REG_NODE_COUNT, 2'b00};
    pwdata  <= adm_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_limit = (int'(value) < MAX_NODES) ? int'(value) : MAX_NODES;
  endtask

  task automatic send_item(
    input logic [OP_W-1:0]    op,
    input logic [IDX_W-1:0]   ni,
    input logic [IDX_W-1:0]   nj,
    input logic [FIELD_W-1:0] re,
    input logic [FIELD_W-1:0] im
  );
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_node_i    <= ni;
    in_node_j    <= nj;
    in_real_part <= re;
    in_imag_part <= im;
    do @(posedge clk); while (!in_ready);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] ni, nj;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 20)      op = adm_pkg::OP_SHUNT;
    else if (r < 38) op = adm_pkg::OP_SERIES;
    else if (r < 52) op = adm_pkg::OP_NODE_CUR;
    else if (r < 66) op = adm_pkg::OP_BRANCH_CUR;
    else if (r < 97) op = adm_pkg::OP_READ;
    else             op = OP_W'($urandom_range(int'(OP_BAD_A), (1 << OP_W) - 1));
    ni = random_node();
    nj = (op == adm_pkg::OP_READ && $urandom_range(0, 2) == 0) ? ni : random_node();
    send_item(op, ni, nj, random_value(), random_value());
  endtask

  // Let every outstanding result arrive, then let the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        // stall long enough for the block to back up into its input
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [NODE_COUNT_W-1:0] count;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = adm_pkg::OP_SHUNT;
    in_node_i    = '0;
    in_node_j    = '0;
    in_real_part = '0;
    in_imag_part = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // widest count: the active limit caps at the node maximum
    cfg_write(7'd127);
    send_item(adm_pkg::OP_READ,       6'd0,  6'd0,  '0,            '0);
    send_item(adm_pkg::OP_SHUNT,      6'd0,  6'd0,  VAL_MAX,       VAL_MIN);
    send_item(adm_pkg::OP_SHUNT,      6'd0,  6'd9,  32'd1,         '1);
    send_item(adm_pkg::OP_READ,       6'd0,  6'd0,  '0,            '0);
    send_item(adm_pkg::OP_SERIES,     6'd62, 6'd63, VAL_MIN,       VAL_MAX);
    send_item(adm_pkg::OP_READ,       6'd62, 6'd63, '0,            '0);
    send_item(adm_pkg::OP_READ,       6'd63, 6'd63, '0,            '0);
    send_item(adm_pkg::OP_SERIES,     6'd5,  6'd5,  32'h0001_0000, 32'hFFFF_8000);
    send_item(adm_pkg::OP_READ,       6'd5,  6'd5,  '0,            '0);
    send_item(adm_pkg::OP_NODE_CUR,   6'd63, 6'd0,  VAL_MAX,       VAL_MAX);
    send_item(adm_pkg::OP_NODE_CUR,   6'd63, 6'd0,  32'd1,         '0);
    send_item(adm_pkg::OP_BRANCH_CUR, 6'd10, 6'd20, VAL_MAX,       VAL_MIN);
    send_item(adm_pkg::OP_READ,       6'd20, 6'd0,  '0,            '0);
    send_item(adm_pkg::OP_BRANCH_CUR, 6'd7,  6'd7,  32'h0003_0000, 32'hFFFF_0000);
    send_item(adm_pkg::OP_READ,       6'd7,  6'd7,  '0,            '0);
    send_item(OP_BAD_A,               6'd63, 6'd63, '1,            '1);
    send_item(OP_BAD_B,               6'd1,  6'd2,  VAL_MAX,       VAL_MIN);
    send_item('1,                     6'd0,  6'd63, 32'h1234_5678, 32'h8765_4321);
    drain();

    // two nodes: indices from two on are out of range
    cfg_write(7'd2);
    send_item(adm_pkg::OP_SHUNT,      6'd2,  6'd0,  32'd5,         32'd5);
    send_item(adm_pkg::OP_SERIES,     6'd1,  6'd2,  32'd5,         32'd5);
    send_item(adm_pkg::OP_NODE_CUR,   6'd0,  6'd63, 32'h0002_0000, 32'h0001_0000);
    send_item(adm_pkg::OP_BRANCH_CUR, 6'd0,  6'd1,  32'h0001_0000, 32'hFFFF_0000);
    send_item(adm_pkg::OP_READ,       6'd1,  6'd63, '0,            '0);
    send_item(adm_pkg::OP_READ,       6'd1,  6'd0,  '0,            '0);
    drain();

    // no nodes at all: everything is flagged except unknown operations
    cfg_write(7'd0);
    send_item(adm_pkg::OP_SHUNT,      6'd0,  6'd0,  32'd1,         32'd1);
    send_item(OP_BAD_B,               6'd0,  6'd0,  '0,            '0);
    send_item(adm_pkg::OP_READ,       6'd0,  6'd0,  '0,            '0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       count = 7'd64;
        1:       count = 7'd1;
        2:       count = 7'd100;
        3:       count = 7'd8;
        4:       count = NODE_COUNT_W'($urandom_range(1, MAX_NODES));
        default: count = NODE_COUNT_W'($urandom_range(0, (1 << NODE_COUNT_W) - 1));
      endcase
      cfg_write(count);
      steady = (phase == 3);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end
    steady = 1'b0;

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/adm_pkg.sv
rtl/adm_ram.sv
rtl/adm_sat_acc.sv
rtl/adm_cfg_regs.sv
rtl/admittance_matrix_stamper.sv
tb/sv/admittance_stamp_check.sv
tb/sv/admittance_matrix_stamper_tb.sv
